// ===== sv/anxsc_pkg.sv =====
// anxsc_pkg: shared types and constants for the annex b start code scanner
// used by every module of the block; no dependencies

package anxsc_pkg;

	localparam int OFFSET_BITS = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int WINDOW_BYTES = 5;

	localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
	localparam logic [4:0] TYPE_AUD = 5'h09;
	localparam logic [4:0] TYPE_IDR = 5'h05;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [7:0] ONE_BYTE = 8'h01;
	localparam logic [2:0] SKIP_AFTER_MATCH = 3'd5;
	localparam logic [OFFSET_BITS:0] FIRST_TEST_COUNT = (OFFSET_BITS + 1)'(4);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       clean_point;
	} item_t;

	typedef struct packed {
		logic                   fragment_valid;
		logic [OFFSET_BITS-1:0] fragment_offset;
		logic [OFFSET_BITS-1:0] fragment_length;
		logic [4:0]             nal_type;
		logic                   keyframe;
		logic                   end_of_buffer;
	} result_t;

	// fragment event between front and back; stop is the closing position
	typedef struct packed {
		logic                   frag_valid;
		logic [OFFSET_BITS-1:0] offset;
		logic [OFFSET_BITS+1:0] stop;
		logic [4:0]             nal_type;
		logic                   keyframe;
		logic                   end_of_buffer;
	} evt_t;

endpackage

// ===== sv/annexb_nal_start_code_scanner_top.sv =====
// annexb_nal_start_code_scanner_top: h.264 annex b start code scanner
// depends on anxsc_pkg, anxsc_front, anxsc_queue, anxsc_back
//
// usage: the item channel (item_valid/item_ready/item) takes one byte of an
// annex b buffer per cycle, with last_byte on the final byte and clean_point
// on the first. the result channel (result_valid/result_ready/result) gives
// one item per fragment closed by a later start code, and exactly one item
// with end_of_buffer set at the end of each buffer, carrying the keyframe flag.
// path: a result passes through the queue and then the output register before
// it appears on result_valid. throughput: one byte per cycle while the queue
// is not full; each byte causes at most one result, so the output register
// drains the event queue as fast as the front fills it.
// reset: arst_n clears the window, counters, open fragment, queue and output
// register; the next byte taken is the first of a buffer.
// stall: while result_ready is low, the result holds; events gather in the
// QUEUE_DEPTH entry queue, and item_ready falls only once the queue is full.

module annexb_nal_start_code_scanner_top #(
	parameter int QUEUE_DEPTH = anxsc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  anxsc_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output anxsc_pkg::result_t result
);

	logic            q_full;
	logic            q_push;
	anxsc_pkg::evt_t q_evt;
	logic            q_pop;
	logic            head_valid;
	anxsc_pkg::evt_t head_evt;

	anxsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_evt      (q_evt)
	);

	anxsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_evt   (q_evt),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_evt   (head_evt)
	);

	anxsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_evt     (head_evt),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== sv/anxsc_front.sv =====
// anxsc_front: byte window, start code detection and fragment tracking
// depends on anxsc_pkg; pushes fragment events into anxsc_queue

module anxsc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  anxsc_pkg::item_t item,
	input  logic             q_full,
	output logic             q_push,
	output anxsc_pkg::evt_t  q_evt
);

	localparam int OB = anxsc_pkg::OFFSET_BITS;

	logic [7:0]    la_q [anxsc_pkg::WINDOW_BYTES];
	logic [OB:0]   bc_q;
	logic [2:0]    skip_q;
	logic          open_q;
	logic [OB-1:0] off_q;
	logic [4:0]    type_q;
	logic          key_q;

	logic          accept;
	logic          key_now;
	logic          test;
	logic          m4;
	logic          m3;
	logic          match;
	logic [4:0]    new_type;
	logic [OB:0]   new_pos;
	logic [OB-1:0] new_off;
	logic [4:0]    w3_type;
	logic [4:0]    w4_type;

	assign item_ready = !q_full;
	assign accept = item_valid && item_ready;
	assign key_now = (bc_q == '0) ? item.clean_point : key_q;

	assign w3_type = la_q[4][4:0] & anxsc_pkg::NAL_TYPE_MASK;
	assign w4_type = item.data_byte[4:0] & anxsc_pkg::NAL_TYPE_MASK;

	assign m4 = (la_q[1] == anxsc_pkg::ZERO_BYTE) && (la_q[2] == anxsc_pkg::ZERO_BYTE) &&
		(la_q[3] == anxsc_pkg::ZERO_BYTE) && (la_q[4] == anxsc_pkg::ONE_BYTE) &&
		(w4_type != anxsc_pkg::TYPE_AUD);
	assign m3 = !m4 && (la_q[1] == anxsc_pkg::ZERO_BYTE) &&
		(la_q[2] == anxsc_pkg::ZERO_BYTE) && (la_q[3] == anxsc_pkg::ONE_BYTE) &&
		(w3_type != anxsc_pkg::TYPE_AUD);

	assign test = !item.last_byte && (bc_q >= anxsc_pkg::FIRST_TEST_COUNT) && (skip_q == '0);
	assign match = test && (m4 || m3);
	assign new_type = m4 ? w4_type : w3_type;
	assign new_pos = m4 ? bc_q : bc_q - (OB + 1)'(1);
	assign new_off = new_pos[OB] ? '1 : new_pos[OB-1:0];

	always_comb begin
		q_evt = '0;
		q_push = 1'b0;
		if (accept && item.last_byte) begin
			q_push = 1'b1;
			q_evt.frag_valid = open_q;
			q_evt.offset = open_q ? off_q : '0;
			q_evt.stop = {1'b0, bc_q} + (OB + 2)'(1);
			q_evt.nal_type = open_q ? type_q : '0;
			q_evt.keyframe = key_now;
			q_evt.end_of_buffer = 1'b1;
		end else if (accept && match && open_q) begin
			q_push = 1'b1;
			q_evt.frag_valid = 1'b1;
			q_evt.offset = off_q;
			q_evt.stop = {1'b0, bc_q} - (OB + 2)'(4);
			q_evt.nal_type = type_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < anxsc_pkg::WINDOW_BYTES; i++) la_q[i] <= '0;
			bc_q <= '0;
			skip_q <= '0;
			open_q <= 1'b0;
			off_q <= '0;
			type_q <= '0;
			key_q <= 1'b0;
		end else if (accept) begin
			if (item.last_byte) begin
				for (int i = 0; i < anxsc_pkg::WINDOW_BYTES; i++) la_q[i] <= '0;
				bc_q <= '0;
				skip_q <= '0;
				open_q <= 1'b0;
				off_q <= '0;
				type_q <= '0;
				key_q <= 1'b0;
			end else begin
				for (int i = 0; i < anxsc_pkg::WINDOW_BYTES - 1; i++) la_q[i] <= la_q[i+1];
				la_q[anxsc_pkg::WINDOW_BYTES-1] <= item.data_byte;
				if (bc_q != '1) bc_q <= bc_q + (OB + 1)'(1);
				if (bc_q >= anxsc_pkg::FIRST_TEST_COUNT && skip_q != '0) skip_q <= skip_q - 3'd1;
				if (match) begin
					skip_q <= anxsc_pkg::SKIP_AFTER_MATCH;
					open_q <= 1'b1;
					off_q <= new_off;
					type_q <= new_type;
				end
				key_q <= key_now || (match && new_type == anxsc_pkg::TYPE_IDR);
			end
		end
	end

endmodule

// ===== sv/anxsc_queue.sv =====
// anxsc_queue: small register queue of fragment events between front and back
// depends on anxsc_pkg

module anxsc_queue #(
	parameter int DEPTH = anxsc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  anxsc_pkg::evt_t push_evt,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output anxsc_pkg::evt_t head_evt
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	anxsc_pkg::evt_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_evt = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== sv/anxsc_back.sv =====
// anxsc_back: turns fragment events into result items with clamped lengths
// depends on anxsc_pkg; drains anxsc_queue into the output register

module anxsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  anxsc_pkg::evt_t    head_evt,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output anxsc_pkg::result_t result
);

	localparam int OB = anxsc_pkg::OFFSET_BITS;

	logic               out_valid_q;
	anxsc_pkg::result_t result_q;
	logic               load;
	logic [OB+1:0]      diff;
	logic [OB-1:0]      length;

	assign load = !out_valid_q || result_ready;
	assign pop = load && head_valid;
	assign diff = head_evt.stop - {2'b00, head_evt.offset};

	always_comb begin
		length = '0;
		if (head_evt.frag_valid && head_evt.stop > {2'b00, head_evt.offset}) begin
			length = (diff[OB+1:OB] != 2'b00) ? '1 : diff[OB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.fragment_valid <= head_evt.frag_valid;
			result_q.fragment_offset <= head_evt.offset;
			result_q.fragment_length <= length;
			result_q.nal_type <= head_evt.nal_type;
			result_q.keyframe <= head_evt.keyframe;
			result_q.end_of_buffer <= head_evt.end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
		end
	end

	assign result_valid = out_valid_q;
	assign result = result_q;

endmodule

// ===== sv/anxsc_checker.sv =====
// anxsc_checker: port level checks of the start code scanner
// depends on anxsc_pkg; bound to annexb_nal_start_code_scanner_top

module anxsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input anxsc_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.fragment_valid || result.end_of_buffer)
		else $error("empty result without end of buffer");

	a_key_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.end_of_buffer |-> !result.keyframe)
		else $error("keyframe flag before end of buffer");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.fragment_valid |->
			result.fragment_offset == '0 && result.fragment_length == '0 &&
			result.nal_type == '0)
		else $error("empty result carries fragment fields");

	// input only backs up behind a waiting result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |-> result_valid)
		else $error("item blocked with no result waiting");

endmodule

bind annexb_nal_start_code_scanner_top anxsc_checker u_anxsc_checker (.*);
